@@ src/fmocc_pkg.sv @@
// Shared constants, types and register map of the FM-index occurrence table builder.
package fmocc_pkg;

    localparam int SYM_W   = 3;   // symbol code and entry symbol width
    localparam int VALUE_W = 64;  // entry value width (bitmap word or count)
    localparam int IVL_W   = 4;   // mark interval register width
    localparam int DATA_W  = 32;  // APB data width
    localparam int ADDR_W  = 3;   // APB byte address width

    localparam int DEF_SYMBOLS   = 5;
    localparam int DEF_WORD_BITS = 64;

    localparam logic [IVL_W-1:0] IVL_RESET = 4'd8;
    localparam logic [IVL_W-1:0] IVL_MIN   = 4'd1;
    localparam logic [IVL_W-1:0] IVL_MAX   = 4'd8;

    // Register index, taken from byte address bit 2
    localparam logic REG_MARK_INTERVAL = 1'b0;

    typedef enum logic
    {
        KIND_WORD = 1'b0,
        KIND_MARK = 1'b1
    } entry_kind_t;

    // Request from the sequencer to the state memories
    typedef struct packed
    {
        logic             rd_en;
        logic [SYM_W-1:0] rd_addr;
        logic             wr_en;
        logic [SYM_W-1:0] wr_addr;
    } mem_ctrl_t;

endpackage

@@ src/fmocc_if.sv @@
// Stream interfaces: symbol input channel and table entry output channel.
interface fmocc_sym_if;
    import fmocc_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol_code;
    logic             end_of_text;

    modport source (output valid, symbol_code, end_of_text, input ready);
    modport sink   (input valid, symbol_code, end_of_text, output ready);
endinterface

interface fmocc_entry_if;
    import fmocc_pkg::*;

    logic               valid;
    logic               ready;
    logic               entry_kind;
    logic [SYM_W-1:0]   entry_symbol;
    logic [VALUE_W-1:0] entry_value;
    logic               final_entry;

    modport source (output valid, entry_kind, entry_symbol, entry_value, final_entry,
                    input ready);
    modport sink   (input valid, entry_kind, entry_symbol, entry_value, final_entry,
                    output ready);
endinterface

@@ src/fm_occ_table_builder_core.sv @@
// Top level of the FM-index occurrence table builder: sequencer, output register, wiring.
//
//  Channel    Dir  Handshake            Payload
//  ---------  ---  -------------------  ----------------------------------------------------
//  sym_in     in   valid/ready          symbol_code[2:0], end_of_text
//  entry_out  out  valid/ready          entry_kind, entry_symbol[2:0], entry_value[63:0],
//                                       final_entry
//  APB        in   psel/penable/pready  paddr[2:0], pwdata/prdata[31:0] (mark_interval @ 0)
//
//  Steps: a symbol that completes no word passes through accept, memory read and
//  read-modify-write. Each group of SYMBOLS entries (word, padding or mark) takes
//  a read step and an emit/write-back step per symbol, set by the single read port
//  of the state memories.
//  Reset: rst_n clears control state and the memory valid bits at once; no clearing
//  pass is needed, so the first symbol is accepted right after reset.
//  Stalls: the output register holds an entry until taken; the sequencer waits in its
//  emit step while that register is full, and sym_in.ready is high only between items.
module fm_occ_table_builder_core #(
    parameter int SYMBOLS   = fmocc_pkg::DEF_SYMBOLS,
    parameter int WORD_BITS = fmocc_pkg::DEF_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fmocc_sym_if.sink                     sym_in,
    fmocc_entry_if.source                 entry_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmocc_pkg::ADDR_W-1:0]  paddr,
    input  logic [fmocc_pkg::DATA_W-1:0]  pwdata,
    output logic [fmocc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import fmocc_pkg::*;

    localparam int               BP_W     = $clog2(WORD_BITS);
    localparam logic [BP_W-1:0]  BP_LAST  = BP_W'(WORD_BITS - 1);
    localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(SYMBOLS - 1);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_GRP_RD,
        ST_GRP_EMIT
    } state_t;

    // Kind of entry group being emitted
    typedef enum logic [2:0]
    {
        GRP_INIT,        // opening zero marks
        GRP_WRAP_WORD,   // full bitmap words
        GRP_WRAP_MARK,   // interval mark after full words
        GRP_FLUSH_WORD,  // partial word at end of text
        GRP_PAD,         // zero words filling the open interval
        GRP_FINAL_MARK   // closing mark
    } group_t;

    state_t              state_reg, state_next;
    group_t              grp_reg, grp_next;
    logic [SYM_W-1:0]    sidx_reg, sidx_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                last_reg, last_next;
    logic [BP_W-1:0]     bitpos_reg, bitpos_next;
    logic [IVL_W-1:0]    words_reg, words_next;
    logic                started_reg, started_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [SYM_W-1:0]    out_sym_reg, out_sym_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    logic                out_final_reg, out_final_next;

    mem_ctrl_t           ctrl;
    logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
    logic [VALUE_W-1:0]  cnt_wdata, cnt_rdata;
    logic [IVL_W-1:0]    interval;

    logic                sym_ok;
    logic                is_mark;
    logic                is_word;
    logic                slot_free;
    logic [IVL_W-1:0]    words_inc;

    fmocc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .interval (interval)
    );

    fmocc_mem #(
        .SYMBOLS   (SYMBOLS),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .bm_wdata  (bm_wdata),
        .cnt_wdata (cnt_wdata),
        .bm_rdata  (bm_rdata),
        .cnt_rdata (cnt_rdata)
    );

    // Out-of-range codes take a bit position but touch no entry
    assign sym_ok    = (int'(sym_reg) < SYMBOLS);
    assign is_mark   = (grp_reg == GRP_INIT) || (grp_reg == GRP_WRAP_MARK)
                    || (grp_reg == GRP_FINAL_MARK);
    assign is_word   = (grp_reg == GRP_WRAP_WORD) || (grp_reg == GRP_FLUSH_WORD);
    assign slot_free = !out_valid_reg || entry_out.ready;
    assign words_inc = words_reg + IVL_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        sidx_next      = sidx_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        bitpos_next    = bitpos_reg;
        words_next     = words_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !entry_out.ready;
        out_kind_next  = out_kind_reg;
        out_sym_next   = out_sym_reg;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        ctrl           = '0;
        bm_wdata       = bm_rdata;
        cnt_wdata      = cnt_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (sym_in.valid)
                begin
                    sym_next  = sym_in.symbol_code;
                    last_next = sym_in.end_of_text;
                    sidx_next = '0;
                    if (!started_reg)
                    begin
                        // Open the table with a zero mark per symbol
                        started_next = 1'b1;
                        grp_next     = GRP_INIT;
                        state_next   = ST_GRP_RD;
                    end
                    else
                    begin
                        state_next = ST_UPD_RD;
                    end
                end
            end

            ST_UPD_RD:
            begin
                ctrl.rd_en   = sym_ok;
                ctrl.rd_addr = sym_reg;
                state_next   = ST_UPD_WR;
            end

            ST_UPD_WR:
            begin
                // Set the bit MSB first and bump the running count
                ctrl.wr_en   = sym_ok;
                ctrl.wr_addr = sym_reg;
                bm_wdata     = bm_rdata | ({1'b1, {(WORD_BITS-1){1'b0}}} >> bitpos_reg);
                cnt_wdata    = cnt_rdata + VALUE_W'(1);
                sidx_next    = '0;
                if (bitpos_reg == BP_LAST)
                begin
                    bitpos_next = '0;
                    grp_next    = GRP_WRAP_WORD;
                    state_next  = ST_GRP_RD;
                end
                else
                begin
                    bitpos_next = bitpos_reg + BP_W'(1);
                    if (last_reg)
                    begin
                        grp_next   = GRP_FLUSH_WORD;
                        state_next = ST_GRP_RD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_GRP_RD:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.rd_addr = sidx_reg;
                state_next   = ST_GRP_EMIT;
            end

            ST_GRP_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = is_mark ? KIND_MARK : KIND_WORD;
                    out_sym_next   = sidx_reg;
                    if (is_mark)
                    begin
                        out_value_next = cnt_rdata;
                    end
                    else if (is_word)
                    begin
                        out_value_next = VALUE_W'(bm_rdata);
                    end
                    else
                    begin
                        out_value_next = '0;
                    end
                    out_final_next = last_reg && (sidx_reg == SYM_LAST)
                                  && ((grp_reg == GRP_WRAP_MARK)
                                   || (grp_reg == GRP_FINAL_MARK));

                    // Drop emitted bitmaps; drop counts on the table's last mark
                    ctrl.wr_addr = sidx_reg;
                    if (is_word)
                    begin
                        ctrl.wr_en = 1'b1;
                        bm_wdata   = '0;
                    end
                    else if (last_reg && (grp_reg != GRP_INIT) && is_mark)
                    begin
                        ctrl.wr_en = 1'b1;
                        cnt_wdata  = '0;
                    end

                    if (sidx_reg != SYM_LAST)
                    begin
                        sidx_next  = sidx_reg + SYM_W'(1);
                        state_next = ST_GRP_RD;
                    end
                    else
                    begin
                        sidx_next = '0;
                        case (grp_reg)
                            GRP_INIT:
                            begin
                                state_next = ST_UPD_RD;
                            end
                            GRP_WRAP_WORD, GRP_FLUSH_WORD, GRP_PAD:
                            begin
                                words_next = words_inc;
                                if ((grp_reg == GRP_WRAP_WORD) && (words_inc >= interval))
                                begin
                                    grp_next   = GRP_WRAP_MARK;
                                    state_next = ST_GRP_RD;
                                end
                                else if ((grp_reg == GRP_WRAP_WORD) && !last_reg)
                                begin
                                    state_next = ST_IDLE;
                                end
                                else
                                begin
                                    // Pad the open interval, then close it
                                    grp_next   = (words_inc < interval) ? GRP_PAD
                                                                        : GRP_FINAL_MARK;
                                    state_next = ST_GRP_RD;
                                end
                            end
                            default:
                            begin
                                // A mark group ends the interval, or the table
                                words_next = '0;
                                state_next = ST_IDLE;
                                if (last_reg)
                                begin
                                    bitpos_next  = '0;
                                    started_next = 1'b0;
                                end
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grp_reg       <= GRP_INIT;
            sidx_reg      <= '0;
            sym_reg       <= '0;
            last_reg      <= 1'b0;
            bitpos_reg    <= '0;
            words_reg     <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
            out_sym_reg   <= '0;
            out_value_reg <= '0;
            out_final_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grp_reg       <= grp_next;
            sidx_reg      <= sidx_next;
            sym_reg       <= sym_next;
            last_reg      <= last_next;
            bitpos_reg    <= bitpos_next;
            words_reg     <= words_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_sym_reg   <= out_sym_next;
            out_value_reg <= out_value_next;
            out_final_reg <= out_final_next;
        end
    end

    assign sym_in.ready           = (state_reg == ST_IDLE);
    assign entry_out.valid        = out_valid_reg;
    assign entry_out.entry_kind   = out_kind_reg;
    assign entry_out.entry_symbol = out_sym_reg;
    assign entry_out.entry_value  = out_value_reg;
    assign entry_out.final_entry  = out_final_reg;

    // The table always closes on a count mark
    a_final_is_mark: assert property (@(posedge clk) disable iff (!rst_n)
        entry_out.valid && entry_out.final_entry |-> entry_out.entry_kind == KIND_MARK)
        else $error("final entry is not a count mark");

    // One item at a time: no second transaction right after an accepted one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sym_in.valid && sym_in.ready |=> !sym_in.ready)
        else $error("input accepted while previous symbol in progress");

    // Write-back stays inside the symbol range
    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_en |-> int'(ctrl.wr_addr) < SYMBOLS)
        else $error("memory write beyond last symbol");

endmodule

@@ src/fmocc_cfg.sv @@
// APB register block holding mark_interval and its clamped working value.
module fmocc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmocc_pkg::ADDR_W-1:0]  paddr,
    input  logic [fmocc_pkg::DATA_W-1:0]  pwdata,
    output logic [fmocc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output logic [fmocc_pkg::IVL_W-1:0]   interval
);
    import fmocc_pkg::*;

    logic [IVL_W-1:0] mark_interval_reg;
    logic [IVL_W-1:0] mark_interval_next;
    logic             sel_ivl;
    logic             wr_hit;

    assign pready  = 1'b1;
    assign sel_ivl = (paddr[ADDR_W-1] == REG_MARK_INTERVAL);
    assign wr_hit  = psel && penable && pwrite && sel_ivl;

    assign mark_interval_next = wr_hit ? pwdata[IVL_W-1:0] : mark_interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_interval_reg <= IVL_RESET;
        end
        else
        begin
            mark_interval_reg <= mark_interval_next;
        end
    end

    assign prdata = sel_ivl ? {{(DATA_W-IVL_W){1'b0}}, mark_interval_reg} : '0;

    // Zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (mark_interval_reg == '0)
        begin
            interval = IVL_MIN;
        end
        else if (mark_interval_reg > IVL_MAX)
        begin
            interval = IVL_MAX;
        end
        else
        begin
            interval = mark_interval_reg;
        end
    end

endmodule

@@ src/fmocc_mem.sv @@
// Per-symbol bitmap and count memories, registered read, valid bit per entry.
module fmocc_mem #(
    parameter int SYMBOLS   = fmocc_pkg::DEF_SYMBOLS,
    parameter int WORD_BITS = fmocc_pkg::DEF_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fmocc_pkg::mem_ctrl_t          ctrl,
    input  logic [WORD_BITS-1:0]          bm_wdata,
    input  logic [fmocc_pkg::VALUE_W-1:0] cnt_wdata,
    output logic [WORD_BITS-1:0]          bm_rdata,
    output logic [fmocc_pkg::VALUE_W-1:0] cnt_rdata
);
    import fmocc_pkg::*;

    localparam int AW = $clog2(SYMBOLS);

    logic [WORD_BITS-1:0] bm_mem  [SYMBOLS];
    logic [VALUE_W-1:0]   cnt_mem [SYMBOLS];

    logic [WORD_BITS-1:0] bm_q_reg;
    logic [VALUE_W-1:0]   cnt_q_reg;
    logic [SYMBOLS-1:0]   vld_reg;
    logic [SYMBOLS-1:0]   vld_next;
    logic                 rd_vld_reg;
    logic                 rd_vld_next;

    // Both words of an entry are always written together
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            bm_mem[ctrl.wr_addr[AW-1:0]]  <= bm_wdata;
            cnt_mem[ctrl.wr_addr[AW-1:0]] <= cnt_wdata;
        end
        if (ctrl.rd_en)
        begin
            bm_q_reg  <= bm_mem[ctrl.rd_addr[AW-1:0]];
            cnt_q_reg <= cnt_mem[ctrl.rd_addr[AW-1:0]];
        end
    end

    assign vld_next = ctrl.wr_en
                    ? (vld_reg | ({{(SYMBOLS-1){1'b0}}, 1'b1} << ctrl.wr_addr[AW-1:0]))
                    : vld_reg;
    assign rd_vld_next = ctrl.rd_en ? vld_reg[ctrl.rd_addr[AW-1:0]] : rd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg    <= vld_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Never-written entries read as zero
    assign bm_rdata  = rd_vld_reg ? bm_q_reg  : '0;
    assign cnt_rdata = rd_vld_reg ? cnt_q_reg : '0;

endmodule

@@ tb/sv/fm_occ_table_builder_checker.sv @@
// Occurrence table checker: predicts table entries from accepted symbols and compares them.
module fm_occ_table_builder_checker
    import fmocc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fmocc_sym_if              sym_mon,
    fmocc_entry_if            entry_mon,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int unsigned       mismatch_count,
    output int unsigned       entries_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM  = DEF_SYMBOLS;
    localparam int WBITS = DEF_WORD_BITS;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        entry_kind_t        kind;
        logic [SYM_W-1:0]   sym;
        logic [VALUE_W-1:0] value;
        logic               closes_table;
    } table_entry_t;

    table_entry_t       entries_pending[$];
    logic [VALUE_W-1:0] occ_bits[NSYM];
    logic [VALUE_W-1:0] occ_total[NSYM];
    int unsigned        word_fill;
    int unsigned        words_since_mark;
    bit                 table_open;
    logic [IVL_W-1:0]   mark_ivl;

    task automatic clear_table();
        for (int s = 0; s < NSYM; s++)
        begin
            occ_bits[s]  = '0;
            occ_total[s] = '0;
        end
        word_fill        = 0;
        words_since_mark = 0;
        table_open       = 1'b0;
    endtask

    task automatic queue_entry(input entry_kind_t kind, input int unsigned sym,
                               input logic [VALUE_W-1:0] value);
        table_entry_t e;
        e.kind         = kind;
        e.sym          = SYM_W'(sym);
        e.value        = value;
        e.closes_table = 1'b0;
        entries_pending.push_back(e);
    endtask

    task automatic queue_marks();
        for (int s = 0; s < NSYM; s++)
            queue_entry(KIND_MARK, s, occ_total[s]);
    endtask

    task automatic queue_words();
        for (int s = 0; s < NSYM; s++)
        begin
            queue_entry(KIND_WORD, s, occ_bits[s]);
            occ_bits[s] = '0;
        end
    endtask

    task automatic add_symbol(input logic [SYM_W-1:0] code, input logic eot);
        int unsigned ivl;
        ivl = 32'((mark_ivl < IVL_MIN) ? IVL_MIN
                : (mark_ivl > IVL_MAX) ? IVL_MAX : mark_ivl);
        if (!table_open)
        begin
            queue_marks();
            table_open = 1'b1;
        end
        // out-of-range codes take a bit position but mark nothing
        if (code < NSYM)
        begin
            occ_bits[code][WBITS-1-word_fill] = 1'b1;
            occ_total[code] += 1;
        end
        if (word_fill == WBITS - 1)
        begin
            word_fill = 0;
            queue_words();
            words_since_mark++;
            if (words_since_mark >= ivl)
            begin
                queue_marks();
                words_since_mark = 0;
            end
        end
        else
            word_fill++;
        if (eot)
        begin
            if (word_fill > 0)
            begin
                queue_words();
                words_since_mark++;
            end
            // pad only up to the interval; a lowered interval gives no padding
            if (words_since_mark > 0)
            begin
                for (int unsigned w = words_since_mark; w < ivl; w++)
                    for (int s = 0; s < NSYM; s++)
                        queue_entry(KIND_WORD, s, '0);
                queue_marks();
            end
            entries_pending[entries_pending.size()-1].closes_table = 1'b1;
            clear_table();
        end
    endtask

    task automatic check_entry();
        table_entry_t want;
        if (entries_pending.size() == 0)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("unexpected entry: kind %0d sym %0d value %h final %0b",
                         entry_mon.entry_kind, entry_mon.entry_symbol,
                         entry_mon.entry_value, entry_mon.final_entry);
            mismatch_count++;
        end
        else
        begin
            want = entries_pending.pop_front();
            if (entry_mon.entry_kind !== want.kind || entry_mon.entry_symbol !== want.sym ||
                entry_mon.entry_value !== want.value ||
                entry_mon.final_entry !== want.closes_table)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("entry mismatch: expected kind %0d sym %0d value %h final %0b,",
                             want.kind, want.sym, want.value, want.closes_table,
                             " got kind %0d sym %0d value %h final %0b",
                             entry_mon.entry_kind, entry_mon.entry_symbol,
                             entry_mon.entry_value, entry_mon.final_entry);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_table();
            mark_ivl = IVL_RESET;
            entries_pending.delete();
            mismatch_count = 0;
            entries_due <= 0;
        end
        else
        begin
            // register index sits in byte address bit 2
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_MARK_INTERVAL)
                mark_ivl = pwdata[IVL_W-1:0];
            if (sym_mon.valid && sym_mon.ready)
                add_symbol(sym_mon.symbol_code, sym_mon.end_of_text);
            if (entry_mon.valid && entry_mon.ready)
                check_entry();
            entries_due <= entries_pending.size();
        end
    end

endmodule

@@ tb/sv/fm_occ_table_builder_core_tb.sv @@
// Testbench top for the occurrence table builder: clock, reset, stimulus and verdict.
module fm_occ_table_builder_core_tb;
    import fmocc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSYM            = DEF_SYMBOLS;
    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    // a symbol that completes no word needs accept, read and write steps; leave a wide margin
    localparam int SETTLE_CYCLES   = 16;
    localparam int PHASE_ITEMS     = 34;
    // worst case: ~350 transactions, each with up to 50 entries
    localparam int CYCLE_LIMIT     = 500_000;

    localparam logic [ADDR_W-1:0] MARK_IVL_ADDR = {REG_MARK_INTERVAL, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR    = {~REG_MARK_INTERVAL, 2'b00};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int unsigned       table_mismatches;
    int unsigned       entries_due;

    // shared between stimulus and the output sink
    bit                calm;
    int unsigned       hold_requests;

    // open table being streamed in, kept across phases so that some tables
    // straddle a change of the mark interval
    int unsigned       table_left;
    bit                flat_table;
    logic [SYM_W-1:0]  flat_code;

    fmocc_sym_if   sym_if();
    fmocc_entry_if entry_if();

    fm_occ_table_builder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_in    (sym_if),
        .entry_out (entry_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    fm_occ_table_builder_checker u_table_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .sym_mon        (sym_if),
        .entry_mon      (entry_if),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (table_mismatches),
        .entries_due    (entries_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: give up once the run has gone far past any correct length.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Output sink: drop ready at random, and on request hold it low for a long
    // stretch so that the output register fills and the input stalls behind it.
    initial
    begin : entry_sink
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left      = 0;
        holds_served   = 0;
        entry_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                entry_if.ready <= 1'b0;
            end
            else
                entry_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Offer one symbol and hold it until the transaction completes; then idle
    // now and again so that gaps land on every step of the block's sequence.
    task automatic offer_symbol(input logic [SYM_W-1:0] code, input logic eot);
        int unsigned gap;
        sym_if.valid       <= 1'b1;
        sym_if.symbol_code <= code;
        sym_if.end_of_text <= eot;
        @(posedge clk);
        while (!sym_if.ready)
            @(posedge clk);
        gap = (!calm && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 3) : 0;
        if (gap != 0)
        begin
            sym_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted entry has been taken, then
    // let the block finish any symbol that produces no entry.
    task automatic settle_table_output();
        sym_if.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (entries_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Quiesce, then program a new mark interval; upper data bits carry junk
    // that the register must ignore.
    task automatic new_phase(input logic [IVL_W-1:0] ivl);
        settle_table_output();
        apb_write(MARK_IVL_ADDR, {(DATA_W-IVL_W)'($urandom), ivl});
    endtask

    // Stream symbols as whole tables of random length: many of them around word
    // boundaries, some short, some spanning several words.
    task automatic stream_tables(input int unsigned n_items);
        logic [SYM_W-1:0] code;
        int unsigned      pick;
        repeat (n_items)
        begin
            if (table_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    table_left = $urandom_range(1, 8);
                else if (pick < 65)
                    table_left = $urandom_range(62, 66);
                else if (pick < 75)
                    table_left = $urandom_range(127, 129);
                else if (pick < 80)
                    table_left = $urandom_range(130, 192);
                else
                    table_left = $urandom_range(9, 61);
                flat_table = ($urandom_range(0, 4) == 0);
                flat_code  = SYM_W'($urandom_range(0, NSYM - 1));
            end
            if (flat_table)
                code = flat_code;
            else if ($urandom_range(0, 99) < 15)
                code = SYM_W'($urandom_range(NSYM, (1 << SYM_W) - 1));
            else
                code = SYM_W'($urandom_range(0, NSYM - 1));
            table_left--;
            offer_symbol(code, table_left == 0);
        end
    endtask

    initial
    begin : stimulus
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sym_if.valid       = 1'b0;
        sym_if.symbol_code = '0;
        sym_if.end_of_text = 1'b0;
        calm               = 1'b0;
        hold_requests      = 0;
        table_left         = 0;
        flat_table         = 1'b0;
        flat_code          = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One-symbol table at the reset interval: opening marks, flushed
        // partial word, padding up to the interval and the closing marks.
        offer_symbol(3'd0, 1'b1);

        // Interval 0 behaves as 1; a write to the unused slot changes nothing.
        new_phase(4'd0);
        apb_write(SPARE_ADDR, DATA_W'(1));
        offer_symbol(3'd4, 1'b1);
        offer_symbol(3'd5, 1'b1);
        offer_symbol(3'd7, 1'b1);
        offer_symbol(3'd6, 1'b1);
        offer_symbol(3'd3, 1'b0);
        offer_symbol(3'd5, 1'b0);
        offer_symbol(3'd1, 1'b0);
        offer_symbol(3'd7, 1'b0);
        offer_symbol(3'd4, 1'b0);
        offer_symbol(3'd2, 1'b0);
        offer_symbol(3'd6, 1'b0);
        offer_symbol(3'd0, 1'b1);

        // Values above the top of the range clamp to 8.
        new_phase(4'd15);
        offer_symbol(3'd2, 1'b1);
        offer_symbol(3'd1, 1'b0);
        offer_symbol(3'd1, 1'b1);

        // End of text on the symbol that completes a word: at interval 1 the
        // word and its marks close the table with nothing flushed. Use one
        // symbol throughout to get an all-ones word.
        new_phase(IVL_MIN);
        table_left = 64;
        flat_table = 1'b1;
        flat_code  = SYM_W'($urandom_range(0, NSYM - 1));
        stream_tables(64);

        // Same boundary at interval 2: one padding word before the marks.
        // Run this one with no idling on either side.
        new_phase(4'd2);
        calm       = 1'b1;
        table_left = 64;
        flat_table = 1'b0;
        stream_tables(64);
        calm       = 1'b0;

        // Random tables across a sweep of intervals; open tables carry over
        // each change, so marks also fire on an interval lowered mid-table.
        new_phase(4'd9);
        stream_tables(PHASE_ITEMS);
        new_phase(4'd4);
        hold_requests++;
        stream_tables(PHASE_ITEMS);
        new_phase(IVL_MIN);
        stream_tables(PHASE_ITEMS);
        new_phase(4'd3);
        stream_tables(PHASE_ITEMS);
        new_phase(IVL_MAX);
        stream_tables(PHASE_ITEMS);
        new_phase(4'd0);
        stream_tables(PHASE_ITEMS);

        // Close whatever table is still open.
        offer_symbol(SYM_W'($urandom_range(0, (1 << SYM_W) - 1)), 1'b1);
        table_left = 0;

        settle_table_output();
        if (table_mismatches == 0 && entries_due == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
src/fmocc_pkg.sv
src/fmocc_if.sv
src/fmocc_cfg.sv
src/fmocc_mem.sv
src/fm_occ_table_builder_core.sv
tb/sv/fm_occ_table_builder_checker.sv
tb/sv/fm_occ_table_builder_core_tb.sv
